FILE: sv/mlk_pkg.sv
package mlk_pkg;

    localparam int CharW    = 8;
    localparam int TimeW    = 16;
    localparam int GapW     = 4;
    localparam int UnitW    = 4;
    localparam int DurW     = TimeW + UnitW;
    localparam int OutDataW = 24;
    localparam int StepW    = 3;
    localparam int CfgIdxW  = 2;
    localparam int ElemW    = 2;
    localparam int LetterW  = 5;

    localparam logic [CharW-1:0] CharSpace = 8'h20;
    localparam logic [CharW-1:0] FoldMask  = 8'hDF;
    localparam logic [CharW-1:0] CharA     = 8'h41;
    localparam logic [CharW-1:0] CharZ     = 8'h5A;

    localparam logic [UnitW-1:0] UnitsDot  = 4'd1;
    localparam logic [UnitW-1:0] UnitsDash = 4'd3;

    localparam logic [TimeW-1:0] TimeBaseRst   = 16'd500;
    localparam logic [GapW-1:0]  ElementGapRst = 4'd5;
    localparam logic [GapW-1:0]  WordGapRst    = 4'd7;
    localparam logic [GapW-1:0]  LetterGapRst  = 4'd3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TIME_BASE,
        REG_ELEMENT_GAP,
        REG_WORD_GAP,
        REG_LETTER_GAP
    } cfg_reg_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT,
        C_LETTER,
        C_SPACE,
        C_MORE
    } cond_t;

    typedef enum logic [2:0] {
        U_ZERO,
        U_ELEM,
        U_EGAP,
        U_LGAP,
        U_WGAP
    } unit_sel_t;

    // Step numbers of the control program.
    localparam logic [StepW-1:0] StepIdle     = 3'd0;
    localparam logic [StepW-1:0] StepIsLetter = 3'd1;
    localparam logic [StepW-1:0] StepIsSpace  = 3'd2;
    localparam logic [StepW-1:0] StepBad      = 3'd3;
    localparam logic [StepW-1:0] StepMark     = 3'd4;
    localparam logic [StepW-1:0] StepElemGap  = 3'd5;
    localparam logic [StepW-1:0] StepLetGap   = 3'd6;
    localparam logic [StepW-1:0] StepWordGap  = 3'd7;

    typedef struct packed {
        logic             emit;
        logic             lamp;
        logic             final_seg;
        logic             bad;
        logic             next_elem;
        unit_sel_t        unit;
        cond_t            cond;
        logic [StepW-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   fire;
        ucode_t cw;
    } ctrl_t;

    typedef struct packed {
        logic is_letter;
        logic is_space;
        logic more;
        logic slot_free;
    } status_t;

    typedef struct packed {
        logic [ElemW-1:0] last_idx;
        logic [3:0]       dash;
    } pattern_t;

    function automatic ucode_t ucode(input logic [StepW-1:0] step);
        ucode_t w;
        w = '{emit: 1'b0, lamp: 1'b0, final_seg: 1'b0, bad: 1'b0, next_elem: 1'b0,
              unit: U_ZERO, cond: C_GOTO, target: StepIdle};
        case (step)
            StepIdle:
            begin
                w.cond = C_WAIT;
            end
            StepIsLetter:
            begin
                w.cond   = C_LETTER;
                w.target = StepMark;
            end
            StepIsSpace:
            begin
                w.cond   = C_SPACE;
                w.target = StepWordGap;
            end
            StepBad:
            begin
                w.emit      = 1'b1;
                w.bad       = 1'b1;
                w.final_seg = 1'b1;
            end
            StepMark:
            begin
                w.emit = 1'b1;
                w.lamp = 1'b1;
                w.unit = U_ELEM;
                w.cond = C_NEXT;
            end
            StepElemGap:
            begin
                w.emit      = 1'b1;
                w.unit      = U_EGAP;
                w.next_elem = 1'b1;
                w.cond      = C_MORE;
                w.target    = StepMark;
            end
            StepLetGap:
            begin
                w.emit      = 1'b1;
                w.unit      = U_LGAP;
                w.final_seg = 1'b1;
            end
            StepWordGap:
            begin
                w.emit      = 1'b1;
                w.unit      = U_WGAP;
                w.final_seg = 1'b1;
            end
            default:
            begin
                w.cond = C_GOTO;
            end
        endcase
        return w;
    endfunction

    // Bit e of dash is set when element e is a dash.
    function automatic pattern_t letter_pattern(input logic [LetterW-1:0] idx);
        pattern_t p;
        case (idx)
            5'd0:    p = '{2'd1, 4'b0010};
            5'd1:    p = '{2'd3, 4'b0001};
            5'd2:    p = '{2'd3, 4'b0101};
            5'd3:    p = '{2'd2, 4'b0001};
            5'd4:    p = '{2'd0, 4'b0000};
            5'd5:    p = '{2'd3, 4'b0100};
            5'd6:    p = '{2'd2, 4'b0011};
            5'd7:    p = '{2'd3, 4'b0000};
            5'd8:    p = '{2'd1, 4'b0000};
            5'd9:    p = '{2'd3, 4'b1110};
            5'd10:   p = '{2'd2, 4'b0101};
            5'd11:   p = '{2'd3, 4'b0010};
            5'd12:   p = '{2'd1, 4'b0011};
            5'd13:   p = '{2'd1, 4'b0001};
            5'd14:   p = '{2'd2, 4'b0111};
            5'd15:   p = '{2'd3, 4'b0110};
            5'd16:   p = '{2'd3, 4'b1011};
            5'd17:   p = '{2'd2, 4'b0010};
            5'd18:   p = '{2'd2, 4'b0000};
            5'd19:   p = '{2'd0, 4'b0001};
            5'd20:   p = '{2'd2, 4'b0100};
            5'd21:   p = '{2'd3, 4'b1000};
            5'd22:   p = '{2'd2, 4'b0110};
            5'd23:   p = '{2'd3, 4'b1001};
            5'd24:   p = '{2'd3, 4'b1101};
            5'd25:   p = '{2'd3, 4'b0011};
            default: p = '{2'd0, 4'b0000};
        endcase
        return p;
    endfunction

endpackage

FILE: sv/mlk_seq.sv
module mlk_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  mlk_pkg::status_t status,
    output mlk_pkg::ctrl_t  ctrl
);
    import mlk_pkg::*;

    logic [StepW-1:0] pc_reg;
    logic [StepW-1:0] pc_next;
    ucode_t           cw;
    logic             stall;
    logic             load;

    assign cw       = ucode(pc_reg);
    assign stall    = cw.emit && !status.slot_free;
    assign s_tready = (cw.cond == C_WAIT);
    assign load     = s_tready && s_tvalid;

    assign ctrl.load = load;
    assign ctrl.fire = !stall;
    assign ctrl.cw   = cw;

    always_comb
    begin
        pc_next = pc_reg;
        if (!stall)
        begin
            case (cw.cond)
                C_NEXT:   pc_next = pc_reg + 3'd1;
                C_GOTO:   pc_next = cw.target;
                C_WAIT:   pc_next = load ? (pc_reg + 3'd1) : pc_reg;
                C_LETTER: pc_next = status.is_letter ? cw.target : (pc_reg + 3'd1);
                C_SPACE:  pc_next = status.is_space ? cw.target : (pc_reg + 3'd1);
                C_MORE:   pc_next = status.more ? cw.target : (pc_reg + 3'd1);
                default:  pc_next = StepIdle;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= StepIdle;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: sv/mlk_dp.sv
module mlk_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mlk_pkg::CharW-1:0]      character,
    input  logic [mlk_pkg::TimeW-1:0]      time_base,
    input  logic [mlk_pkg::GapW-1:0]       element_gap,
    input  logic [mlk_pkg::GapW-1:0]       word_gap,
    input  logic [mlk_pkg::GapW-1:0]       letter_gap,
    input  mlk_pkg::ctrl_t                 ctrl,
    output mlk_pkg::status_t               status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           lamp_on,
    output logic [mlk_pkg::DurW-1:0]       duration,
    output logic                           bad_character,
    output logic                           final_segment
);
    import mlk_pkg::*;

    logic [CharW-1:0] char_reg;
    logic [ElemW-1:0] idx_reg;
    logic             valid_reg;
    logic             lamp_reg;
    logic [DurW-1:0]  dur_reg;
    logic             bad_reg;
    logic             final_reg;

    logic [CharW-1:0] folded;
    logic [CharW-1:0] letter_off;
    pattern_t         pat;
    logic [UnitW-1:0] units;
    logic [DurW-1:0]  product;
    logic             emit_now;

    assign folded     = char_reg & FoldMask;
    assign letter_off = folded - CharA;
    assign pat        = letter_pattern(letter_off[LetterW-1:0]);

    assign status.is_space  = (char_reg == CharSpace);
    assign status.is_letter = (folded >= CharA) && (folded <= CharZ);
    assign status.more      = (idx_reg != pat.last_idx);
    assign status.slot_free = !valid_reg || out_ready;

    always_comb
    begin
        case (ctrl.cw.unit)
            U_ELEM:  units = pat.dash[idx_reg] ? UnitsDash : UnitsDot;
            U_EGAP:  units = element_gap;
            U_LGAP:  units = letter_gap;
            U_WGAP:  units = word_gap;
            default: units = '0;
        endcase
    end

    assign product  = {{UnitW{1'b0}}, time_base} * {{TimeW{1'b0}}, units};
    assign emit_now = ctrl.fire && ctrl.cw.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_now)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            char_reg <= character;
            idx_reg  <= '0;
        end
        else if (ctrl.fire && ctrl.cw.next_elem)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
        if (emit_now)
        begin
            lamp_reg  <= ctrl.cw.lamp;
            dur_reg   <= product;
            bad_reg   <= ctrl.cw.bad;
            final_reg <= ctrl.cw.final_seg;
        end
    end

    assign out_valid     = valid_reg;
    assign lamp_on       = lamp_reg;
    assign duration      = dur_reg;
    assign bad_character = bad_reg;
    assign final_segment = final_reg;

endmodule

FILE: sv/morse_letter_keyer_core.sv
// A letter's first beat is registered from the mark step, which the program reaches
// from the idle step through the letter test; a space or any other code goes on through
// the space test to the word-gap or bad-code step. Then one beat per cycle while the output
// is taken, set by the control program that emits one segment per step and stalls otherwise.
// Reset (rst_n, asynchronous, active low) returns the program to its idle step, empties
// the output register and loads the timing registers with their default values.
module morse_letter_keyer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // character
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mlk_pkg::OutDataW-1:0]      m_tdata,   // lamp_on, duration, zero pad
    output logic                              m_tlast,
    output logic                              m_tuser,   // bad_character
    input  logic                              cfg_we,
    input  logic [mlk_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [mlk_pkg::TimeW-1:0]         cfg_data
);
    import mlk_pkg::*;

    logic [TimeW-1:0] time_base_reg;
    logic [GapW-1:0]  element_gap_reg;
    logic [GapW-1:0]  word_gap_reg;
    logic [GapW-1:0]  letter_gap_reg;

    ctrl_t            ctrl;
    status_t          status;
    logic             lamp_on;
    logic [DurW-1:0]  duration;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_reg   <= TimeBaseRst;
            element_gap_reg <= ElementGapRst;
            word_gap_reg    <= WordGapRst;
            letter_gap_reg  <= LetterGapRst;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TIME_BASE:   time_base_reg   <= cfg_data;
                REG_ELEMENT_GAP: element_gap_reg <= cfg_data[GapW-1:0];
                REG_WORD_GAP:    word_gap_reg    <= cfg_data[GapW-1:0];
                REG_LETTER_GAP:  letter_gap_reg  <= cfg_data[GapW-1:0];
                default:         ;
            endcase
        end
    end

    mlk_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    mlk_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .character     (s_tdata),
        .time_base     (time_base_reg),
        .element_gap   (element_gap_reg),
        .word_gap      (word_gap_reg),
        .letter_gap    (letter_gap_reg),
        .ctrl          (ctrl),
        .status        (status),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .lamp_on       (lamp_on),
        .duration      (duration),
        .bad_character (m_tuser),
        .final_segment (m_tlast)
    );

    assign m_tdata = {{(OutDataW - DurW - 1){1'b0}}, duration, lamp_on};

endmodule
